/* rtl/writeback_lru_cache_tag_model_assert.svh */
// assertion macros shared by the cache tag model rtl
`ifndef WRITEBACK_LRU_CACHE_TAG_MODEL_ASSERT_SVH
`define WRITEBACK_LRU_CACHE_TAG_MODEL_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define WLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define WLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/wlc_pkg.sv */
// ---------------------------------------------------------------------------
// wlc_pkg
// shared types and constants of the cache tag model
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wlc_pkg;
    localparam int unsigned WAY_FIELD_W = 3;
    localparam int unsigned CNT_W       = 32;

    // controller to datapath
    typedef struct packed {
        logic start;    // latch input word, launch row read
        logic lookup;   // row data valid, register hit and victim
        logic update;   // write row back, bump counters, load result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
    } t_status;
endpackage
`default_nettype wire

/* rtl/wlc_if.sv */
// ---------------------------------------------------------------------------
// wlc_if
// valid/ready channel carrying one payload word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface wlc_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/wlc_ram.sv */
// ---------------------------------------------------------------------------
// wlc_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wlc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/wlc_datapath.sv */
// ---------------------------------------------------------------------------
// wlc_datapath
// set row storage, tag compare, victim choice, lru update and counters
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wlc_datapath #(
    parameter int unsigned SET_BITS    = 6,
    parameter int unsigned WAYS        = 8,
    parameter int unsigned OFFSET_BITS = 6,
    parameter int unsigned ADDR_BITS   = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire wlc_pkg::t_cmd              i_cmd,
    output wlc_pkg::t_status                o_status,
    input  wire logic [31:0]                i_address,
    input  wire logic                       i_is_store,
    output logic                            o_hit,
    output logic                            o_writeback,
    output logic [wlc_pkg::WAY_FIELD_W-1:0] o_way_used,
    output logic [wlc_pkg::CNT_W-1:0]       o_load_miss_count,
    output logic [wlc_pkg::CNT_W-1:0]       o_store_miss_count,
    output logic [wlc_pkg::CNT_W-1:0]       o_writeback_count
);
    localparam int unsigned SETS  = 1 << SET_BITS;
    localparam int unsigned RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned TAG_W = (ADDR_BITS > OFFSET_BITS + SET_BITS)
                                    ? ADDR_BITS - OFFSET_BITS - SET_BITS : 1;
    localparam int unsigned TAG_R = (ADDR_BITS > OFFSET_BITS + SET_BITS)
                                    ? ADDR_BITS - OFFSET_BITS - SET_BITS : 0;
    // one way: valid, dirty, rank, tag
    localparam int unsigned ENT_W = 2 + RW + TAG_W;
    localparam int unsigned ROW_W = WAYS * ENT_W;
    localparam logic [wlc_pkg::CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [RW-1:0]    rank;
        logic [TAG_W-1:0] tag;
    } t_ent;

    // address zero-extended to 64 bits and cut at ADDR_BITS
    logic [63:0]         w_addr;
    logic [SET_BITS-1:0] w_set;
    logic [TAG_W-1:0]    w_tag;

    always_comb begin
        w_addr = {32'd0, i_address};
        if (ADDR_BITS < 64) begin
            w_addr = w_addr & ((64'd1 << ADDR_BITS) - 64'd1);
        end
        w_set = SET_BITS'(w_addr >> OFFSET_BITS);
        w_tag = '0;
        if (TAG_R > 0) begin
            w_tag = TAG_W'(w_addr >> (OFFSET_BITS + SET_BITS));
        end
    end

    logic [SET_BITS-1:0] r_set;
    logic [TAG_W-1:0]    r_tag;
    logic                r_store;
    logic                r_clearing;
    logic [SET_BITS:0]   r_clr_cnt;

    logic [ROW_W-1:0] w_rdata;
    logic [ROW_W-1:0] w_wdata;
    logic [ROW_W-1:0] w_clr_row;
    logic             w_we;
    logic [SET_BITS-1:0] w_waddr;
    t_ent             r_row [WAYS];
    t_ent             n_row [WAYS];
    logic             r_hit;
    logic             r_wb;
    logic [RW-1:0]    r_way;

    // reset image of a row: invalid, rank equals way
    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            w_clr_row[k*ENT_W +: ENT_W] = {2'b00, RW'(k), TAG_W'(0)};
        end
    end

    wlc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_set),
        .o_rdata(w_rdata)
    );

    // compare and victim choice on the registered row
    t_ent          w_ent [WAYS];
    logic          w_hit;
    logic [RW-1:0] w_hway;
    logic          w_inv;
    logic [RW-1:0] w_iway;
    logic [RW-1:0] w_lway;
    logic [RW-1:0] w_vict;

    always_comb begin
        w_hit  = 1'b0;
        w_hway = '0;
        w_inv  = 1'b0;
        w_iway = '0;
        w_lway = '0;
        for (int k = WAYS - 1; k >= 0; k--) begin
            w_ent[k] = t_ent'(w_rdata[k*ENT_W +: ENT_W]);
            if (w_ent[k].valid && w_ent[k].tag == r_tag) begin
                w_hit  = 1'b1;
                w_hway = RW'(k);
            end
            if (!w_ent[k].valid) begin
                w_inv  = 1'b1;
                w_iway = RW'(k);
            end
            if (w_ent[k].rank == RW'(WAYS - 1)) begin
                w_lway = RW'(k);
            end
        end
        w_vict = w_hit ? w_hway : (w_inv ? w_iway : w_lway);
    end

    // next row from the registered lookup
    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            n_row[k] = r_row[k];
            if (r_row[k].rank < r_row[r_way].rank) begin
                n_row[k].rank = r_row[k].rank + RW'(1);
            end
        end
        n_row[r_way].rank = '0;
        if (r_hit) begin
            if (r_store) begin
                n_row[r_way].dirty = 1'b1;
            end
        end else begin
            n_row[r_way].valid = 1'b1;
            n_row[r_way].dirty = r_store;
            n_row[r_way].tag   = r_tag;
        end
        for (int k = 0; k < WAYS; k++) begin
            w_wdata[k*ENT_W +: ENT_W] = n_row[k];
        end
        if (r_clearing) begin
            w_wdata = w_clr_row;
        end
    end

    assign w_we    = r_clearing || i_cmd.update;
    assign w_waddr = r_clearing ? r_clr_cnt[SET_BITS-1:0] : r_set;
    assign o_status.clear_done = !r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing         <= 1'b1;
            r_clr_cnt          <= '0;
            o_load_miss_count  <= '0;
            o_store_miss_count <= '0;
            o_writeback_count  <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == (SET_BITS+1)'(SETS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cmd.update) begin
                o_hit       <= r_hit;
                o_writeback <= r_wb;
                o_way_used  <= wlc_pkg::WAY_FIELD_W'({{(32 - RW){1'b0}}, r_way});
                if (!r_hit) begin
                    if (r_store) begin
                        if (o_store_miss_count != CNT_MAX) begin
                            o_store_miss_count <= o_store_miss_count + 1'b1;
                        end
                    end else if (o_load_miss_count != CNT_MAX) begin
                        o_load_miss_count <= o_load_miss_count + 1'b1;
                    end
                    if (r_wb && o_writeback_count != CNT_MAX) begin
                        o_writeback_count <= o_writeback_count + 1'b1;
                    end
                end
            end
        end
        if (i_cmd.start) begin
            r_set   <= w_set;
            r_tag   <= w_tag;
            r_store <= i_is_store;
        end
        if (i_cmd.lookup) begin
            r_row <= w_ent;
            r_hit <= w_hit;
            r_way <= w_vict;
            r_wb  <= !w_hit && w_ent[w_vict].valid && w_ent[w_vict].dirty;
        end
    end

    `include "writeback_lru_cache_tag_model_assert.svh"
    `WLC_ASSERT_NEXT(a_hit_no_wb, i_clk, i_rst_n, i_cmd.lookup && w_hit, !r_wb)
    `WLC_ASSERT_IMP(a_no_update_clearing, i_clk, i_rst_n, r_clearing, !i_cmd.update && !i_cmd.start)
    `WLC_ASSERT_NEXT(a_wb_needs_miss, i_clk, i_rst_n, i_cmd.update, !(o_hit && o_writeback))
endmodule
`default_nettype wire

/* rtl/wlc_ctrl.sv */
// ---------------------------------------------------------------------------
// wlc_ctrl
// sequencer: accept, read row, decide, write back and present result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wlc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire wlc_pkg::t_status i_status,
    output wlc_pkg::t_cmd         o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_DECIDE, S_WRITE} t_state;
    t_state r_state;

    // a held result only blocks a new write of the output register
    assign o_in_ready = (r_state == S_IDLE) && i_status.clear_done;
    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = o_in_ready && i_in_valid;
        o_cmd.lookup = (r_state == S_READ);
        o_cmd.update = (r_state == S_WRITE) && (!o_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE:   if (o_cmd.start) r_state <= S_READ;
                S_READ:   r_state <= S_DECIDE;
                S_DECIDE: r_state <= S_WRITE;
                S_WRITE: begin
                    if (o_cmd.update) begin
                        r_state     <= S_IDLE;
                        o_out_valid <= 1'b1;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    `include "writeback_lru_cache_tag_model_assert.svh"
    `WLC_ASSERT_NEXT(a_start_reads, i_clk, i_rst_n, o_cmd.start, r_state == S_READ)
    `WLC_ASSERT_NEXT(a_update_shows, i_clk, i_rst_n, o_cmd.update, o_out_valid)
    `WLC_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd))
endmodule
`default_nettype wire

/* rtl/writeback_lru_cache_tag_model.sv */
// ---------------------------------------------------------------------------
// writeback_lru_cache_tag_model
// tag-only set-associative write-back cache with true lru replacement
// ---------------------------------------------------------------------------
// channel   dir  payload
// i_req     in   address[31:0], is_store
// o_rsp     out  hit, writeback, way_used[2:0], three 32-bit miss/wb counts
//
// each word passes through accept, row read, decide and row write
// the row read and the decision are both registered
// after reset a clearing pass over all 2**SET_BITS sets runs before the first accept
// the result register holds a finished word; input is accepted while it waits
// a stalled output stalls only the row write of the next word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module writeback_lru_cache_tag_model #(
    parameter int unsigned SET_BITS    = 6,
    parameter int unsigned WAYS        = 8,
    parameter int unsigned OFFSET_BITS = 6,
    parameter int unsigned ADDR_BITS   = 32
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    wlc_if.sink      i_req,
    wlc_if.source    o_rsp
);
    wlc_pkg::t_cmd    w_cmd;
    wlc_pkg::t_status w_status;
    logic             w_hit;
    logic             w_wb;
    logic [wlc_pkg::WAY_FIELD_W-1:0] w_way;
    logic [wlc_pkg::CNT_W-1:0] w_lm, w_sm, w_wc;

    // control sequencer
    wlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // row storage, compare and counters
    wlc_datapath #(
        .SET_BITS   (SET_BITS),
        .WAYS       (WAYS),
        .OFFSET_BITS(OFFSET_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_address         (i_req.data[32:1]),
        .i_is_store        (i_req.data[0]),
        .o_hit             (w_hit),
        .o_writeback       (w_wb),
        .o_way_used        (w_way),
        .o_load_miss_count (w_lm),
        .o_store_miss_count(w_sm),
        .o_writeback_count (w_wc)
    );

    // response word: hit, writeback, way, load, store, wb counts
    assign o_rsp.data = {w_hit, w_wb, w_way, w_lm, w_sm, w_wc};
endmodule
`default_nettype wire

/* tb/sv/writeback_lru_cache_tag_model_tb.sv */
// ---------------------------------------------------------------------------
// writeback_lru_cache_tag_model_tb
// drives load/store accesses into the cache tag model and checks each result
// word field by field against a behavioral lru cache kept in the testbench
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module writeback_lru_cache_tag_model_tb;
    localparam int unsigned SET_BITS    = 6;
    localparam int unsigned WAYS        = 8;
    localparam int unsigned OFFSET_BITS = 6;
    localparam int unsigned ADDR_BITS   = 32;
    localparam int unsigned NUM_SETS    = 1 << SET_BITS;
    localparam int unsigned REQ_W       = 33;
    localparam int unsigned RSP_W       = 2 + wlc_pkg::WAY_FIELD_W + 3 * wlc_pkg::CNT_W;
    localparam logic [wlc_pkg::CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                            hit;
        logic                            writeback;
        logic [wlc_pkg::WAY_FIELD_W-1:0] way_used;
        logic [wlc_pkg::CNT_W-1:0]       load_miss_count;
        logic [wlc_pkg::CNT_W-1:0]       store_miss_count;
        logic [wlc_pkg::CNT_W-1:0]       writeback_count;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    wlc_if #(.W(REQ_W)) req_ch ();
    wlc_if #(.W(RSP_W)) rsp_ch ();

    writeback_lru_cache_tag_model #(
        .SET_BITS(SET_BITS), .WAYS(WAYS), .OFFSET_BITS(OFFSET_BITS), .ADDR_BITS(ADDR_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow copy of the cache tag state
    logic        shadow_valid [NUM_SETS][WAYS];
    logic        shadow_dirty [NUM_SETS][WAYS];
    logic [31:0] shadow_tag   [NUM_SETS][WAYS];
    int unsigned shadow_rank  [NUM_SETS][WAYS];
    logic [wlc_pkg::CNT_W-1:0] n_load_miss, n_store_miss, n_wb;

    t_result pending_results[$];
    int      error_count;
    bit      hold_off;          // receiver stalls while set
    bit      rx_random_stall;   // random receiver gaps enabled

    function automatic logic [wlc_pkg::CNT_W-1:0] bump(input logic [wlc_pkg::CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // lookup, replace and update recency, returning the expected result word
    function automatic t_result predict_access(input logic [31:0] addr, input logic store);
        t_result r;
        int unsigned set_idx, victim, old_rank;
        logic [31:0] tag;
        bit found;
        set_idx = (addr >> OFFSET_BITS) & (NUM_SETS - 1);
        tag     = addr >> (OFFSET_BITS + SET_BITS);
        r       = '0;
        victim  = 0;
        found   = 0;
        for (int w = 0; w < WAYS; w++)
            if (!found && shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
                found  = 1;
                victim = w;
            end
        if (found) begin
            r.hit = 1'b1;
            if (store)
                shadow_dirty[set_idx][victim] = 1'b1;
        end else begin
            // first invalid way, else the least recent one
            for (int w = WAYS - 1; w >= 0; w--)
                if (!shadow_valid[set_idx][w]) begin
                    victim = w;
                    found  = 1;
                end
            if (!found)
                for (int w = 0; w < WAYS; w++)
                    if (shadow_rank[set_idx][w] == WAYS - 1)
                        victim = w;
            if (shadow_valid[set_idx][victim] && shadow_dirty[set_idx][victim]) begin
                r.writeback = 1'b1;
                n_wb = bump(n_wb);
            end
            if (store)
                n_store_miss = bump(n_store_miss);
            else
                n_load_miss = bump(n_load_miss);
            shadow_valid[set_idx][victim] = 1'b1;
            shadow_tag[set_idx][victim]   = tag;
            shadow_dirty[set_idx][victim] = store;
        end
        old_rank = shadow_rank[set_idx][victim];
        for (int w = 0; w < WAYS; w++)
            if (shadow_rank[set_idx][w] < old_rank)
                shadow_rank[set_idx][w]++;
        shadow_rank[set_idx][victim] = 0;
        r.way_used         = victim[wlc_pkg::WAY_FIELD_W-1:0];
        r.load_miss_count  = n_load_miss;
        r.store_miss_count = n_store_miss;
        r.writeback_count  = n_wb;
        return r;
    endfunction

    // send one access word after a random gap unless no_gap is set; prediction made on acceptance
    task automatic send_access(input logic [31:0] addr, input logic store, input bit no_gap = 0);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= {addr, store};
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        pending_results.push_back(predict_access(addr, store));
        @(negedge i_clk);
    endtask

    task automatic idle_sender();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] make_addr(input logic [31:0] tag, input int unsigned set_idx);
        return (tag << (OFFSET_BITS + SET_BITS)) | (set_idx << OFFSET_BITS)
            | $urandom_range(0, (1 << OFFSET_BITS) - 1);
    endfunction

    // receiver ready, held off while hold_off is set, with random stalls drawn per word when enabled
    initial begin
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = rx_random_stall ? $urandom_range(0, 15) : 0;
            if (hold_off || stall != 0) begin
                rsp_ch.ready <= 1'b0;
                while (hold_off)
                    @(negedge i_clk);
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid)
                @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = t_result'(rsp_ch.data);
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, got.hit);
                    error_count++;
                end
                if (got.writeback !== want.writeback) begin
                    $error("writeback: expected %0d actual %0d", want.writeback, got.writeback);
                    error_count++;
                end
                if (got.way_used !== want.way_used) begin
                    $error("way_used: expected %0d actual %0d", want.way_used, got.way_used);
                    error_count++;
                end
                if (got.load_miss_count !== want.load_miss_count) begin
                    $error("load_miss_count: expected %0d actual %0d",
                           want.load_miss_count, got.load_miss_count);
                    error_count++;
                end
                if (got.store_miss_count !== want.store_miss_count) begin
                    $error("store_miss_count: expected %0d actual %0d",
                           want.store_miss_count, got.store_miss_count);
                    error_count++;
                end
                if (got.writeback_count !== want.writeback_count) begin
                    $error("writeback_count: expected %0d actual %0d",
                           want.writeback_count, got.writeback_count);
                    error_count++;
                end
            end
        end
    end

    // address extremes, both access kinds
    task automatic test_field_extremes();
        send_access(32'h0000_0000, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'hAAAA_AAAA, 1'b0);
        send_access(32'h5555_5555, 1'b1);
    endtask

    // load hit keeps dirty, store hit sets it, fill then evict dirty lines
    task automatic test_fill_and_evict();
        for (int t = 0; t < WAYS; t++)
            send_access(make_addr(t + 1, 5), t[0]);
        send_access(make_addr(1, 5), 1'b0);    // load hit on a line left clean
        send_access(make_addr(2, 5), 1'b0);    // load hit on a dirty line
        send_access(make_addr(1, 5), 1'b1);    // store hit marks dirty
        for (int t = 0; t < 4; t++)
            send_access(make_addr(t + 20, 5), 1'b0);  // lru victims, some dirty
    endtask

    // back to back words to one set with no gaps
    task automatic test_same_set_burst();
        for (int i = 0; i < 10; i++)
            send_access(make_addr($urandom_range(0, 11), 9), $urandom_range(0, 1), 1);
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_output_backpressure();
        hold_off = 1;
        fork
            for (int i = 0; i < 12; i++)
                send_access(make_addr($urandom_range(0, 3), $urandom_range(0, 3)), 1'b1, 1);
            begin
                repeat (200) @(negedge i_clk);
                hold_off = 0;
            end
        join
    endtask

    // random traffic: mostly a small pool of tags per set for hits and evictions
    task automatic test_random_traffic();
        logic [31:0] addr;
        for (int i = 0; i < 900; i++) begin
            rx_random_stall = ((i / 150) % 2) == 0;
            case ($urandom_range(0, 9))
                0: addr = $urandom();
                1, 2: addr = make_addr($urandom(), $urandom_range(0, NUM_SETS - 1));
                default: addr = make_addr($urandom_range(0, 11), $urandom_range(0, 7));
            endcase
            send_access(addr, $urandom_range(0, 1), rx_random_stall ? 0 : 1);
        end
    endtask

    initial begin
        error_count     = 0;
        hold_off        = 0;
        rx_random_stall = 1;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.data     = '0;
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < WAYS; w++) begin
                shadow_valid[s][w] = 1'b0;
                shadow_dirty[s][w] = 1'b0;
                shadow_tag[s][w]   = '0;
                shadow_rank[s][w]  = w;
            end
        n_load_miss  = '0;
        n_store_miss = '0;
        n_wb         = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_field_extremes();
        test_fill_and_evict();
        test_same_set_burst();
        test_output_backpressure();
        test_random_traffic();
        idle_sender();

        // drain, then a short settle for stray words
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/wlc_pkg.sv
rtl/wlc_if.sv
rtl/wlc_ram.sv
rtl/wlc_datapath.sv
rtl/wlc_ctrl.sv
rtl/writeback_lru_cache_tag_model.sv
tb/sv/writeback_lru_cache_tag_model_tb.sv
